FILE: src/assert_macros.svh
// Assertion macros shared by the token scanner RTL.
// Depends on nothing; users provide clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds on every clock edge outside reset.
`define DTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never becomes true outside reset.
`define DTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define DTS_ASSERT(lbl, prop, msg)
`define DTS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: src/dts_pkg.sv
// Shared types, token kinds, character codes and keyword table of the token scanner.
// Depends on nothing.
package dts_pkg;

  localparam int unsigned LINE_BITS_DEF   = 16;
  localparam int unsigned LENGTH_BITS_DEF = 16;

  // Token kinds as seen on the result channel
  localparam logic [4:0] KIND_COMMA     = 5'd0;
  localparam logic [4:0] KIND_PERIOD    = 5'd1;
  localparam logic [4:0] KIND_QMARK     = 5'd2;
  localparam logic [4:0] KIND_LPAREN    = 5'd3;
  localparam logic [4:0] KIND_RPAREN    = 5'd4;
  localparam logic [4:0] KIND_COLON     = 5'd5;
  localparam logic [4:0] KIND_COLONDASH = 5'd6;
  localparam logic [4:0] KIND_MUL       = 5'd7;
  localparam logic [4:0] KIND_ADD       = 5'd8;
  localparam logic [4:0] KIND_SCHEMES   = 5'd9;
  localparam logic [4:0] KIND_ID        = 5'd13;
  localparam logic [4:0] KIND_STRING    = 5'd14;
  localparam logic [4:0] KIND_COMMENT   = 5'd15;
  localparam logic [4:0] KIND_UNDEF     = 5'd16;
  localparam logic [4:0] KIND_EOF       = 5'd17;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  // Scanner modes, one-hot
  typedef enum logic [8:0] {
    MODE_IDLE     = 9'b000000001,
    MODE_COLON    = 9'b000000010,
    MODE_STR      = 9'b000000100,
    MODE_STRQ     = 9'b000001000,
    MODE_HASH     = 9'b000010000,
    MODE_LINEC    = 9'b000100000,
    MODE_BLOCK    = 9'b001000000,
    MODE_BLOCKBAR = 9'b010000000,
    MODE_IDENT    = 9'b100000000
  } lex_mode_e;

  // Keywords, left aligned, zero padded to seven bytes
  localparam logic [55:0] KW_STR [4] = '{
    "Schemes",
    {"Facts", 16'h0000},
    {"Rules", 16'h0000},
    "Queries"
  };
  localparam logic [2:0] KW_LEN [4] = '{3'd7, 3'd5, 3'd5, 3'd7};

  // One result record
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] length;
    logic        last;
  } token_t;

  // Tokens handed from the scanner to the output buffer in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    token_t     t0;
    token_t     t1;
  } tok_push_t;

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [55:0] s;
    s = KW_STR[k];
    return s[55 - 8 * int'(p) -: 8];
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

FILE: src/dts_if.sv
// Valid/ready channel interfaces of the token scanner: source bytes in, tokens out.
// Depends on nothing.
interface dts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface dts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_line;
  logic [15:0] token_length;
  logic        last;

  modport source (output valid, output token_kind, output token_line,
                  output token_length, output last, input ready);
  modport sink   (input valid, input token_kind, input token_line,
                  input token_length, input last, output ready);
endinterface

FILE: src/datalog_token_scanner.sv
// Top level of the Datalog token scanner: byte channel in, token channel out.
// Depends on dts_pkg, dts_if, dts_scan and dts_outbuf.
//
//   channel  dir  beat carries                                  handshake
//   in_i     in   ch[7:0], end_of_input                         valid/ready
//   out_o    out  token_kind[4:0], token_line[15:0],            valid/ready
//                 token_length[15:0], last
//
// One byte beat per cycle while the buffer has room; each byte is held in the
// input register, scanned there, and its 0, 1 or 2 tokens land in the two-entry
// result buffer. The buffer drains one token per cycle while out_o is ready; a
// byte that ends a token and starts another pushes both; the buffer's room sets ready.
// Reset (rst_ni low, asynchronous) puts the scanner between tokens on line 1.
// After the end-of-file token every further beat is accepted and dropped.
module datalog_token_scanner #(
  parameter int unsigned LINE_BITS   = dts_pkg::LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = dts_pkg::LENGTH_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dts_in_if.sink    in_i,
  dts_out_if.source out_o
);
  import dts_pkg::*;

  tok_push_t  push;
  logic [1:0] free;

  dts_scan #(
    .LINE_BITS  (LINE_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .free_i(free),
    .push_o(push)
  );

  dts_outbuf u_outbuf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .free_o(free),
    .out_o (out_o)
  );

endmodule

FILE: src/dts_scan.sv
// Input register and lexer state machine: turns one byte beat into up to two tokens.
// Depends on dts_pkg, dts_if and assert_macros.svh.
module dts_scan #(
  parameter int unsigned LINE_BITS   = dts_pkg::LINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = dts_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dts_in_if.sink             in_i,
  input  logic [1:0]         free_i,
  output dts_pkg::tok_push_t push_o
);
  import dts_pkg::*;

  `include "assert_macros.svh"

  logic                   in_vld_q;
  logic [7:0]             ch_q;
  logic                   eoi_q;
  lex_mode_e              mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d, line_inc;
  logic [LINE_BITS-1:0]   start_q, start_d;
  logic [LENGTH_BITS-1:0] len_q, len_d, len_inc;
  logic [3:0]             cand_q, cand_d, cand_take;
  logic                   fin_q, fin_d;
  logic                   fire;

  logic       idle_emit, idle_start, idle_bump;
  logic [4:0] idle_kind;
  lex_mode_e  idle_mode;
  logic [3:0] idle_cand;
  logic [4:0] ident_kind;

  logic       pre_vld, post_vld, use_idle;
  token_t     pre_tok, post_tok;
  logic [1:0] n_tok;
  token_t     t0, t1;

  function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
    if (LINE_BITS > 16 && (v >> 16) != '0) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic logic [15:0] sat_len(input logic [LENGTH_BITS-1:0] v);
    if (LENGTH_BITS > 16 && (v >> 16) != '0) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic token_t mk_tok(input logic [4:0] kind,
                                    input logic [LINE_BITS-1:0] line,
                                    input logic [LENGTH_BITS-1:0] len);
    token_t t;
    t.kind   = kind;
    t.line   = sat_line(line);
    t.length = sat_len(len);
    t.last   = 1'b0;
    return t;
  endfunction

  // Saturating increments
  assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
  assign len_inc  = (len_q == '1) ? len_q : len_q + LENGTH_BITS'(1);

  // Keyword tracking: drop candidates that mismatch at the current position
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cand_take[k] = cand_q[k] && (len_q < LENGTH_BITS'(KW_LEN[k]))
                     && (kw_char(2'(k), len_q[2:0]) == ch_q);
      idle_cand[k] = (kw_char(2'(k), 3'd0) == ch_q);
    end
  end

  // Resolve identifier kind, lowest keyword index wins
  always_comb begin
    ident_kind = KIND_ID;
    for (int k = 3; k >= 0; k--) begin
      if (cand_q[k] && len_q == LENGTH_BITS'(KW_LEN[k])) begin
        ident_kind = KIND_SCHEMES + 5'(k);
      end
    end
  end

  // Decode a byte seen between tokens
  always_comb begin
    idle_emit  = 1'b0;
    idle_kind  = KIND_UNDEF;
    idle_mode  = MODE_IDLE;
    idle_start = 1'b0;
    idle_bump  = 1'b0;
    unique case (ch_q)
      CH_NL:            idle_bump = 1'b1;
      CH_SPACE, CH_TAB: ;
      CH_COMMA:  begin idle_emit = 1'b1; idle_kind = KIND_COMMA;  end
      CH_PERIOD: begin idle_emit = 1'b1; idle_kind = KIND_PERIOD; end
      CH_QMARK:  begin idle_emit = 1'b1; idle_kind = KIND_QMARK;  end
      CH_LPAREN: begin idle_emit = 1'b1; idle_kind = KIND_LPAREN; end
      CH_RPAREN: begin idle_emit = 1'b1; idle_kind = KIND_RPAREN; end
      CH_STAR:   begin idle_emit = 1'b1; idle_kind = KIND_MUL;    end
      CH_PLUS:   begin idle_emit = 1'b1; idle_kind = KIND_ADD;    end
      CH_COLON:  begin idle_mode = MODE_COLON; idle_start = 1'b1; end
      CH_QUOTE:  begin idle_mode = MODE_STR;   idle_start = 1'b1; end
      CH_HASH:   begin idle_mode = MODE_HASH;  idle_start = 1'b1; end
      default: begin
        if (is_letter(ch_q)) begin
          idle_mode  = MODE_IDENT;
          idle_start = 1'b1;
        end else begin
          idle_emit = 1'b1;
        end
      end
    endcase
  end

  // Main scanner step
  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    start_d  = start_q;
    len_d    = len_q;
    cand_d   = cand_q;
    fin_d    = fin_q;
    pre_vld  = 1'b0;
    pre_tok  = mk_tok(KIND_UNDEF, start_q, len_q);
    post_vld = 1'b0;
    post_tok = mk_tok(KIND_UNDEF, line_q, LENGTH_BITS'(1));
    use_idle = 1'b0;

    if (!fin_q) begin
      if (eoi_q) begin
        // Flush the open token, then end of file on the next line
        pre_vld = (mode_q != MODE_IDLE);
        unique case (mode_q)
          MODE_COLON:                pre_tok = mk_tok(KIND_COLON, start_q, LENGTH_BITS'(1));
          MODE_STR:                  pre_tok = mk_tok(KIND_UNDEF, start_q, len_q);
          MODE_STRQ:                 pre_tok = mk_tok(KIND_STRING, start_q, len_q);
          MODE_HASH, MODE_LINEC:     pre_tok = mk_tok(KIND_COMMENT, start_q, len_q);
          MODE_BLOCK, MODE_BLOCKBAR: pre_tok = mk_tok(KIND_UNDEF, start_q, len_q);
          MODE_IDENT:                pre_tok = mk_tok(ident_kind, start_q, len_q);
          default:                   pre_vld = 1'b0;
        endcase
        post_vld = 1'b1;
        post_tok = mk_tok(KIND_EOF, line_inc, '0);
        line_d   = line_inc;
        mode_d   = MODE_IDLE;
        fin_d    = 1'b1;
      end else begin
        unique case (mode_q)
          MODE_COLON: begin
            if (ch_q == CH_DASH) begin
              pre_vld = 1'b1;
              pre_tok = mk_tok(KIND_COLONDASH, start_q, LENGTH_BITS'(2));
              mode_d  = MODE_IDLE;
            end else begin
              pre_vld  = 1'b1;
              pre_tok  = mk_tok(KIND_COLON, start_q, LENGTH_BITS'(1));
              use_idle = 1'b1;
            end
          end
          MODE_STR: begin
            len_d = len_inc;
            if (ch_q == CH_NL) line_d = line_inc;
            else if (ch_q == CH_QUOTE) mode_d = MODE_STRQ;
          end
          MODE_STRQ: begin
            if (ch_q == CH_QUOTE) begin
              len_d  = len_inc;
              mode_d = MODE_STR;
            end else begin
              pre_vld  = 1'b1;
              pre_tok  = mk_tok(KIND_STRING, start_q, len_q);
              use_idle = 1'b1;
            end
          end
          MODE_HASH, MODE_LINEC: begin
            if (mode_q == MODE_HASH && ch_q == CH_BAR) begin
              len_d  = len_inc;
              mode_d = MODE_BLOCK;
            end else if (ch_q == CH_NL) begin
              pre_vld  = 1'b1;
              pre_tok  = mk_tok(KIND_COMMENT, start_q, len_q);
              use_idle = 1'b1;
            end else begin
              len_d  = len_inc;
              mode_d = MODE_LINEC;
            end
          end
          MODE_BLOCK, MODE_BLOCKBAR: begin
            len_d = len_inc;
            if (mode_q == MODE_BLOCKBAR && ch_q == CH_HASH) begin
              pre_vld = 1'b1;
              pre_tok = mk_tok(KIND_COMMENT, start_q, len_inc);
              mode_d  = MODE_IDLE;
            end else if (ch_q == CH_NL) begin
              line_d = line_inc;
              mode_d = MODE_BLOCK;
            end else if (ch_q == CH_BAR) begin
              mode_d = MODE_BLOCKBAR;
            end else begin
              mode_d = MODE_BLOCK;
            end
          end
          MODE_IDENT: begin
            if (is_letter(ch_q) || is_digit(ch_q)) begin
              cand_d = cand_take;
              len_d  = len_inc;
            end else begin
              pre_vld  = 1'b1;
              pre_tok  = mk_tok(ident_kind, start_q, len_q);
              use_idle = 1'b1;
            end
          end
          default: use_idle = 1'b1;
        endcase

        // Rescan the byte as the start of a new token
        if (use_idle) begin
          mode_d   = idle_mode;
          post_vld = idle_emit;
          post_tok = mk_tok(idle_kind, line_q, LENGTH_BITS'(1));
          line_d   = idle_bump ? line_inc : line_q;
          if (idle_start) begin
            start_d = line_q;
            len_d   = LENGTH_BITS'(1);
            cand_d  = idle_cand;
          end
        end
      end
    end
  end

  // Pack tokens in order and flag the final one
  always_comb begin
    n_tok = {1'b0, pre_vld} + {1'b0, post_vld};
    t0    = pre_vld ? pre_tok : post_tok;
    t1    = post_tok;
    if (n_tok == 2'd2) t1.last = 1'b1;
    else               t0.last = 1'b1;
  end

  // Advance when the output buffer has room for every token of this beat
  assign fire        = in_vld_q && (n_tok <= free_i);
  assign in_i.ready  = !in_vld_q || fire;
  assign push_o.cnt  = fire ? n_tok : 2'd0;
  assign push_o.t0   = t0;
  assign push_o.t1   = t1;

  // Input register, control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input register, payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q  <= in_i.ch;
      eoi_q <= in_i.end_of_input;
    end
  end

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= LINE_BITS'(1);
      start_q <= '0;
      len_q   <= '0;
      cand_q  <= '0;
      fin_q   <= 1'b0;
    end else if (fire) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      start_q <= start_d;
      len_q   <= len_d;
      cand_q  <= cand_d;
      fin_q   <= fin_d;
    end
  end

  `DTS_ASSERT(a_fin_sticky, fin_q |=> fin_q, "end-of-input flag cleared before reset")
  `DTS_ASSERT(a_fin_silent, fin_q |-> push_o.cnt == 2'd0, "token produced after end of file")
  `DTS_ASSERT(a_pair_last, (push_o.cnt == 2'd2) |-> (push_o.t1.last && !push_o.t0.last),
              "last flag misplaced on a token pair")

endmodule

FILE: src/dts_outbuf.sv
// Two-entry result buffer: takes up to two tokens per cycle, presents one per beat.
// Depends on dts_pkg, dts_if and assert_macros.svh.
module dts_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dts_pkg::tok_push_t push_i,
  output logic [1:0]         free_o,
  dts_out_if.source          out_o
);
  import dts_pkg::*;

  `include "assert_macros.svh"

  logic [1:0] cnt_q, cnt_d, rem_cnt;
  token_t     s0_q, s0_d, s1_q, s1_d;
  logic       pop;

  // Head entry drives the channel
  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.token_kind   = s0_q.kind;
  assign out_o.token_line   = s0_q.line;
  assign out_o.token_length = s0_q.length;
  assign out_o.last         = s0_q.last;

  assign pop     = out_o.valid && out_o.ready;
  assign rem_cnt = cnt_q - {1'b0, pop};
  assign free_o  = 2'd2 - rem_cnt;
  assign cnt_d   = rem_cnt + push_i.cnt;

  // Shift out the popped entry, append new tokens behind the survivors
  always_comb begin
    s0_d = s0_q;
    s1_d = s1_q;
    unique case (rem_cnt)
      2'd0: begin
        s0_d = push_i.t0;
        s1_d = push_i.t1;
      end
      2'd1: begin
        s0_d = pop ? s1_q : s0_q;
        s1_d = push_i.t0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  `DTS_ASSERT_NEVER(a_cnt_range, cnt_q == 2'd3, "result buffer count out of range")
  `DTS_ASSERT_NEVER(a_no_overflow, push_i.cnt > free_o, "tokens pushed beyond free space")
  `DTS_ASSERT(a_head_promote, (pop && cnt_q == 2'd2) |=> (s0_q == $past(s1_q)),
              "second entry not promoted after a beat")

endmodule
